@@ hdl/cwpt_pkg.sv @@
// Shared constants, types and wait-state decode functions for the prefetch timer.
`timescale 1ns / 1ps

package cwpt_pkg;

    localparam int ADDR_W       = 28;
    localparam int TICK_W       = 6;
    localparam int FILL_W       = 5;
    localparam int CNT_W        = 4;
    localparam int CYC_W        = 5;
    localparam int IN_DATA_W    = 40;
    localparam int OUT_DATA_W   = 72;
    localparam int BUFFER_BYTES = 16;

    // register indexes on the configuration port
    localparam logic REG_WAIT_LOW  = 1'b0;
    localparam logic REG_WAIT_HIGH = 1'b1;

    // item kinds carried in tuser
    localparam logic MODE_ADVANCE = 1'b0;
    localparam logic MODE_START   = 1'b1;

    localparam int PF_EN_BIT = 6;

    typedef struct packed {
        logic accept;  // latch the incoming word
        logic start;   // restart prefetch at the word's address
        logic tick;    // one elapsed bus cycle
        logic load;    // capture the result into the output register
    } cwpt_cmd_t;

    // wait region from the upper address nibble: 0 = wait0, 1 = wait1, 2 = wait2
    function automatic logic [1:0] wait_region(input logic [3:0] nib);
        logic [1:0] r;
        case (nib[3:1])
            3'd0:    r = 2'd1;
            3'd1:    r = 2'd2;
            3'd2:    r = 2'd0;
            3'd3:    r = 2'd1;
            3'd4:    r = 2'd0;
            3'd5:    r = 2'd1;
            3'd6:    r = 2'd2;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic [CNT_W-1:0] n_wait(input logic [1:0] sel);
        logic [CNT_W-1:0] w;
        case (sel)
            2'd0:    w = 4'd4;
            2'd1:    w = 4'd3;
            2'd2:    w = 4'd2;
            default: w = 4'd8;
        endcase
        return w;
    endfunction

    function automatic logic [CNT_W-1:0] s_wait(input logic [1:0] region, input logic sel);
        logic [CNT_W-1:0] w;
        if (sel) begin
            w = 4'd1;
        end else begin
            case (region)
                2'd0:    w = 4'd2;
                2'd1:    w = 4'd4;
                default: w = 4'd8;
            endcase
        end
        return w;
    endfunction

endpackage

@@ hdl/cart_waitstate_prefetch_timer.sv @@
// Top level of the cartridge wait-state decoder and prefetch buffer timer.
// Usage:
//   Input words arrive on s_axis_*: tuser is the mode (0 advance, 1 start
//   prefetch at the address); tdata carries address, ticks, sequential flag
//   and access width. Each word yields exactly one result word on m_axis_*:
//   buffer start, last fetch address, fill in bytes, countdown and the cycle
//   cost of the queried access at the word's address.
//   Wait-control bytes are written through cfg_we/cfg_addr/cfg_wdata while
//   the block is idle; writing the high byte with prefetch newly enabled
//   empties the buffer.
// Sequencing:
//   A start word goes from acceptance straight to the finishing state, where
//   it loads its result. An advance word first steps its ticks (all of them,
//   or fewer once the countdown is idle): the countdown unit steps one bus
//   cycle per clock. One word is in flight at a time; the next is accepted
//   as soon as the previous result sits in the output register.
// Reset clears the wait-control registers, the buffer state and the output valid.
// A stalled receiver holds the result; a finished word then waits in the
// sequencer until the output register frees up.
`timescale 1ns / 1ps

module cart_waitstate_prefetch_timer (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic                                 cfg_addr,
    input  logic [7:0]                           cfg_wdata,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // address[27:0], ticks[33:28], sequential[34], access_width[36:35], zero fill
    input  logic [cwpt_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // mode[0]
    input  logic                                 s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // fill_start[27:0], fetch_address[55:28], fill_bytes[60:56],
    // cycles_left[64:61], access_cycles[69:65], zero fill
    output logic [cwpt_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);

    cwpt_pkg::cwpt_cmd_t cmd;
    logic                cd_zero;

    cwpt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_mode   (s_axis_tuser),
        .in_ticks  (s_axis_tdata[33:28]),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cd_zero   (cd_zero),
        .cmd       (cmd)
    );

    cwpt_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .cmd             (cmd),
        .in_address      (s_axis_tdata[27:0]),
        .in_sequential   (s_axis_tdata[34]),
        .in_access_width (s_axis_tdata[36:35]),
        .cd_zero         (cd_zero),
        .out_data        (m_axis_tdata)
    );

endmodule

@@ hdl/cwpt_ctrl.sv @@
// Sequencer for the prefetch timer: accepts a word, steps ticks, loads the result.
`timescale 1ns / 1ps

module cwpt_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_mode,
    input  logic [cwpt_pkg::TICK_W-1:0]   in_ticks,
    output logic                          in_ready,
    output logic                          out_valid,
    input  logic                          out_ready,
    input  logic                          cd_zero,
    output cwpt_pkg::cwpt_cmd_t           cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]                        state_reg, state_next;
    logic [cwpt_pkg::TICK_W-1:0]       ticks_reg, ticks_next;
    logic                              ovalid_reg, ovalid_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = ovalid_reg;

    always_comb
    begin
        state_next  = state_reg;
        ticks_next  = ticks_reg;
        ovalid_next = ovalid_reg;
        cmd         = '0;
        if (ovalid_reg && out_ready) begin
            ovalid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid) begin
                    cmd.accept = 1'b1;
                    cmd.start  = (in_mode == cwpt_pkg::MODE_START);
                    ticks_next = in_ticks;
                    state_next = (in_mode == cwpt_pkg::MODE_START) ? ST_FIN : ST_RUN;
                end
            end
            ST_RUN:
            begin
                // an idle countdown swallows the remaining ticks
                if (ticks_reg == '0 || cd_zero) begin
                    state_next = ST_FIN;
                end else begin
                    cmd.tick   = 1'b1;
                    ticks_next = ticks_reg - 1'b1;
                end
            end
            ST_FIN:
            begin
                if (!ovalid_reg || out_ready) begin
                    cmd.load    = 1'b1;
                    ovalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg  <= ST_IDLE;
            ticks_reg  <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            ticks_reg  <= ticks_next;
            ovalid_reg <= ovalid_next;
        end
    end

endmodule

@@ hdl/cwpt_dp.sv @@
// Datapath: wait-control registers, prefetch buffer state, timing decode, result register.
`timescale 1ns / 1ps

module cwpt_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic                              cfg_addr,
    input  logic [7:0]                        cfg_wdata,
    input  cwpt_pkg::cwpt_cmd_t               cmd,
    input  logic [cwpt_pkg::ADDR_W-1:0]       in_address,
    input  logic                              in_sequential,
    input  logic [1:0]                        in_access_width,
    output logic                              cd_zero,
    output logic [cwpt_pkg::OUT_DATA_W-1:0]   out_data
);

    logic [7:0]                       low_reg;
    logic [7:0]                       high_reg;
    logic                             was_on_reg;
    logic [cwpt_pkg::ADDR_W-1:0]      start_reg, start_next;
    logic [cwpt_pkg::ADDR_W-1:0]      fetch_reg, fetch_next;
    logic [cwpt_pkg::FILL_W-1:0]      fill_reg, fill_next;
    logic [cwpt_pkg::CNT_W-1:0]       cd_reg, cd_next;
    logic [cwpt_pkg::ADDR_W-1:0]      addr_reg;
    logic                             seq_reg;
    logic [1:0]                       width_reg;
    logic [cwpt_pkg::OUT_DATA_W-1:0]  out_reg;

    logic [cwpt_pkg::ADDR_W-1:0]      fetch_inc;
    logic [cwpt_pkg::FILL_W-1:0]      fill_inc;
    logic [cwpt_pkg::CNT_W-1:0]       cd_dec;
    logic                             pf_clear;
    logic [3:0]                       q_nib;
    logic [1:0]                       q_reg;
    logic [cwpt_pkg::CNT_W-1:0]       q_nw;
    logic [cwpt_pkg::CNT_W-1:0]       q_sw;
    logic [cwpt_pkg::CYC_W-1:0]       q_cycles;

    // sequential wait select bit of a region
    function automatic logic wait_sel(input logic [1:0] region);
        logic s;
        case (region)
            2'd0:    s = low_reg[4];
            2'd1:    s = low_reg[7];
            default: s = high_reg[2];
        endcase
        return s;
    endfunction

    assign cd_zero  = (cd_reg == '0);
    assign fetch_inc = fetch_reg + cwpt_pkg::ADDR_W'(2);
    assign fill_inc  = fill_reg + cwpt_pkg::FILL_W'(2);
    assign cd_dec    = cd_reg - 1'b1;
    assign pf_clear  = cfg_we && (cfg_addr == cwpt_pkg::REG_WAIT_HIGH)
                       && cfg_wdata[cwpt_pkg::PF_EN_BIT] && !was_on_reg;

    always_comb
    begin
        start_next = start_reg;
        fetch_next = fetch_reg;
        fill_next  = fill_reg;
        cd_next    = cd_reg;
        if (pf_clear) begin
            start_next = '0;
            fetch_next = '0;
            fill_next  = '0;
            cd_next    = '0;
        end else if (cmd.start) begin
            start_next = in_address;
            fetch_next = in_address;
            fill_next  = '0;
            cd_next    = 4'd1 + cwpt_pkg::s_wait(
                             cwpt_pkg::wait_region(in_address[27:24]),
                             wait_sel(cwpt_pkg::wait_region(in_address[27:24])));
        end else if (cmd.tick) begin
            if (cd_dec == '0) begin
                // countdown elapsed: one halfword lands in the buffer
                fetch_next = fetch_inc;
                cd_next    = 4'd1 + cwpt_pkg::s_wait(
                                 cwpt_pkg::wait_region(fetch_inc[27:24]),
                                 wait_sel(cwpt_pkg::wait_region(fetch_inc[27:24])));
                if (fill_inc > cwpt_pkg::FILL_W'(cwpt_pkg::BUFFER_BYTES)) begin
                    fill_next  = cwpt_pkg::FILL_W'(cwpt_pkg::BUFFER_BYTES);
                    start_next = start_reg + cwpt_pkg::ADDR_W'(2);
                end else begin
                    fill_next  = fill_inc;
                end
            end else begin
                cd_next = cd_dec;
            end
        end
    end

    // access timing of the latched query
    always_comb
    begin
        q_nib = addr_reg[27:24];
        q_reg = cwpt_pkg::wait_region(q_nib);
        case (q_reg)
            2'd0:    q_nw = cwpt_pkg::n_wait(low_reg[3:2]);
            2'd1:    q_nw = cwpt_pkg::n_wait(low_reg[6:5]);
            default: q_nw = cwpt_pkg::n_wait(high_reg[1:0]);
        endcase
        q_sw = cwpt_pkg::s_wait(q_reg, wait_sel(q_reg));
        if (q_nib >= 4'd14) begin
            q_cycles = 5'd1 + {1'b0, cwpt_pkg::n_wait(low_reg[1:0])};
        end else if (seq_reg) begin
            q_cycles = width_reg[1] ? (({1'b0, q_sw} + 5'd1) << 1) :
                                      5'd1 + {1'b0, q_sw};
        end else begin
            q_cycles = width_reg[1] ? 5'd2 + {1'b0, q_nw} + {1'b0, q_sw} :
                                      5'd1 + {1'b0, q_nw};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            low_reg    <= '0;
            high_reg   <= '0;
            was_on_reg <= 1'b0;
            start_reg  <= '0;
            fetch_reg  <= '0;
            fill_reg   <= '0;
            cd_reg     <= '0;
        end else begin
            if (cfg_we) begin
                if (cfg_addr == cwpt_pkg::REG_WAIT_LOW) begin
                    low_reg <= cfg_wdata;
                end else begin
                    high_reg   <= cfg_wdata;
                    was_on_reg <= cfg_wdata[cwpt_pkg::PF_EN_BIT];
                end
            end
            start_reg <= start_next;
            fetch_reg <= fetch_next;
            fill_reg  <= fill_next;
            cd_reg    <= cd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept) begin
            addr_reg  <= in_address;
            seq_reg   <= in_sequential;
            width_reg <= in_access_width;
        end
        if (cmd.load) begin
            out_reg <= {2'b00, q_cycles, cd_reg, fill_reg, fetch_reg, start_reg};
        end
    end

    assign out_data = out_reg;

endmodule

@@ hdl/cwpt_checker.sv @@
// Port-level checks for the prefetch timer, bound to the top level.
`timescale 1ns / 1ps

module cwpt_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [cwpt_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result word dropped while stalled");

    a_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    a_fill_max: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[60:56] <= 5'd16)
        else $error("fill beyond buffer size");

    a_fill_even: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !m_axis_tdata[56])
        else $error("fill is not whole halfwords");

    a_cycles_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[69:65] != 5'd0) && (m_axis_tdata[69:65] <= 5'd18))
        else $error("access cycles out of range");

endmodule

bind cart_waitstate_prefetch_timer cwpt_checker u_cwpt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
